// ===== rtl/kwms_pkg.sv =====
// Shared types and constants of the k-way merge head selector.
`default_nettype none

package kwms_pkg;

   // Default geometry of the list store.
   localparam int LISTS_DEFAULT   = 8;
   localparam int ENTRIES_DEFAULT = 64;

   // Field widths of the request and response transactions.
   localparam int IDX_W      = 3;
   localparam int SEG_W      = 16;
   localparam int IDENT_W    = 31;
   localparam int FILE_W     = 32;
   localparam int KIND_W     = 2;
   localparam int COUNT_W    = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   // Bit positions inside req_tdata.
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_SEG_LSB   = REQ_IDX_LSB + IDX_W;
   localparam int REQ_IDENT_LSB = REQ_SEG_LSB + SEG_W;
   localparam int REQ_USED_W    = REQ_IDENT_LSB + IDENT_W;

   // Bit positions inside rsp_tdata.
   localparam int RSP_SEG_LSB  = 0;
   localparam int RSP_FILE_LSB = RSP_SEG_LSB + SEG_W;

   localparam logic [COUNT_W-1:0] LIST_COUNT_RESET = 4'd2;
   localparam logic [SEG_W-1:0]   NO_SEGMENT       = '1;
   localparam logic [FILE_W-1:0]  NO_FILE          = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_SET    = 2'd1,
      KIND_NEXT   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/kwms_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module kwms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/kway_merge_head_selector_unit.sv =====
// Top level of the k-way merge head selector: list store, scan sequencer and response register.
`default_nettype none

//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------------------------
//  req     | in        | req_tvalid/req_tready | tuser: kind; tdata: list_index, segment, ident
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: chosen_segment, chosen_file; tuser: done
//  csr     | in        | csr_wr_en             | csr_wr_data: list_count
//
// A next transaction passes through the accepting cycle, one descriptor read for each of the
// min(list_count, LISTS) scanned lists, the RAM read pipeline and a commit; with list_count
// zero the scan is skipped. Append and set read the descriptor, then write it back; a clear
// completes in the accepting cycle. Reset is synchronous with no clearing pass: descriptor
// valid bits are flops cleared at once. A result waiting on rsp stalls the commit of the next
// result, and no new request is accepted while that commit waits.

module kway_merge_head_selector_unit #(
   parameter int LISTS   = kwms_pkg::LISTS_DEFAULT,
   parameter int ENTRIES = kwms_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration: list_count in bits 3:0.
   input  wire logic                                csr_wr_en,
   input  wire logic [kwms_pkg::COUNT_W-1:0]        csr_wr_data,
   // Request channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata from bit 0 up: list_index[2:0], segment_number[18:3], file_ident[49:19], zeros.
   input  wire logic [kwms_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: kind[1:0].
   input  wire logic [kwms_pkg::KIND_W-1:0]         req_tuser,
   // Response channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata from bit 0 up: chosen_segment[15:0], chosen_file[47:16].
   output logic      [kwms_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: done_res[0].
   output logic      [0:0]                          rsp_tuser
);

   localparam int IW    = $clog2(LISTS);
   localparam int CW    = $clog2(LISTS + 1);
   localparam int LW    = $clog2(ENTRIES + 1);
   localparam int DEPTH = LISTS * ENTRIES;
   localparam int AW    = $clog2(DEPTH);

   // Per-list descriptor held in the descriptor RAM.
   typedef struct packed {
      logic [kwms_pkg::SEG_W-1:0] seg;
      logic [LW-1:0]              len;
      logic [LW-1:0]              head;
   } meta_type;

   localparam int MW = $bits(meta_type);
   localparam meta_type META_RESET = '{seg: kwms_pkg::NO_SEGMENT, len: '0, head: '0};

   // Request field unpacking.
   kwms_pkg::kind_type             req_kind;
   logic [kwms_pkg::IDX_W-1:0]     req_idx;
   logic [kwms_pkg::SEG_W-1:0]     req_seg;
   logic [kwms_pkg::IDENT_W-1:0]   req_ident;
   logic                           req_accept;

   assign req_kind  = kwms_pkg::kind_type'(req_tuser);
   assign req_idx   = req_tdata[kwms_pkg::REQ_IDX_LSB +: kwms_pkg::IDX_W];
   assign req_seg   = req_tdata[kwms_pkg::REQ_SEG_LSB +: kwms_pkg::SEG_W];
   assign req_ident = req_tdata[kwms_pkg::REQ_IDENT_LSB +: kwms_pkg::IDENT_W];

   // Control state.
   kwms_pkg::state_type state_ff, state_in;
   logic [kwms_pkg::COUNT_W-1:0] list_count_ff, list_count_in;
   logic [LISTS-1:0]             meta_vld_ff, meta_vld_in;
   logic                         meta_rvld_ff, meta_rvld_in;
   logic [CW-1:0]                iss_ff, iss_in;
   logic [CW-1:0]                scan_n_ff, scan_n_in;
   logic                         s1_v_ff, s1_v_in;
   logic                         s1_last_ff, s1_last_in;
   logic                         s2_v_ff, s2_v_in;
   logic                         s2_last_ff, s2_last_in;
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   kwms_pkg::kind_type             kind_ff, kind_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic [kwms_pkg::SEG_W-1:0]     seg_ff, seg_in;
   logic [kwms_pkg::IDENT_W-1:0]   ident_ff, ident_in;
   logic [IW-1:0]                  s1_idx_ff, s1_idx_in;
   logic                           s2_cand_ff, s2_cand_in;
   logic [IW-1:0]                  s2_idx_ff, s2_idx_in;
   meta_type                       s2_meta_ff, s2_meta_in;
   logic [IW-1:0]                  best_idx_ff, best_idx_in;
   meta_type                       best_meta_ff, best_meta_in;
   logic [kwms_pkg::IDENT_W-1:0]   best_id_ff, best_id_in;
   logic [kwms_pkg::SEG_W-1:0]     rsp_seg_ff, rsp_seg_in;
   logic [kwms_pkg::FILE_W-1:0]    rsp_file_ff, rsp_file_in;
   logic                           rsp_done_ff, rsp_done_in;

   // Memory ports.
   logic                         meta_we;
   logic [IW-1:0]                meta_waddr;
   meta_type                     meta_wdata;
   logic [IW-1:0]                meta_raddr;
   logic [MW-1:0]                meta_rdata;
   logic                         id_we;
   logic [AW-1:0]                id_waddr;
   logic [AW-1:0]                id_raddr;
   logic [kwms_pkg::IDENT_W-1:0] id_rdata;

   // Derived values.
   meta_type      meta_cur;
   logic [CW-1:0] lists_in_use;
   logic          idx_in_range;
   logic          out_free;
   logic          s1_cand;

   assign req_tready = (state_ff == kwms_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // An entry without its valid bit reads as a freshly cleared list.
   assign meta_cur = meta_rvld_ff ? meta_type'(meta_rdata) : META_RESET;

   // Lists taking part in a merge saturate at the number of lists present.
   assign lists_in_use = (int'(list_count_ff) > LISTS) ? CW'(LISTS) : CW'(list_count_ff);
   assign idx_in_range = (int'(req_idx) < LISTS);

   // A list competes when it is in use and still has unread identifiers.
   assign s1_cand = !meta_cur.seg[kwms_pkg::SEG_W-1] && (meta_cur.head < meta_cur.len);

   kwms_ram #(
      .WIDTH (MW),
      .DEPTH (LISTS),
      .AW    (IW)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   kwms_ram #(
      .WIDTH (kwms_pkg::IDENT_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (ident_ff),
      .rd_addr (id_raddr),
      .rd_data (id_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kwms_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  kwms_pkg::KIND_APPEND, kwms_pkg::KIND_SET: begin
                     if (idx_in_range) begin
                        state_in = kwms_pkg::ST_LOAD;
                     end
                  end
                  kwms_pkg::KIND_NEXT: begin
                     state_in = (lists_in_use == '0) ? kwms_pkg::ST_COMMIT
                                                     : kwms_pkg::ST_SCAN;
                  end
                  default: state_in = kwms_pkg::ST_IDLE;
               endcase
            end
         end
         kwms_pkg::ST_LOAD: state_in = kwms_pkg::ST_IDLE;
         kwms_pkg::ST_SCAN: begin
            if (s2_v_ff && s2_last_ff) begin
               state_in = kwms_pkg::ST_COMMIT;
            end
         end
         kwms_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = kwms_pkg::ST_IDLE;
            end
         end
         default: state_in = kwms_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      list_count_in = csr_wr_en ? csr_wr_data : list_count_ff;
      meta_vld_in   = meta_vld_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      seg_in        = seg_ff;
      ident_in      = ident_ff;
      iss_in        = iss_ff;
      scan_n_in     = scan_n_ff;
      s1_v_in       = 1'b0;
      s1_last_in    = 1'b0;
      s1_idx_in     = iss_ff[IW-1:0];
      s2_v_in       = 1'b0;
      s2_last_in    = s1_last_ff;
      s2_cand_in    = s1_cand;
      s2_idx_in     = s1_idx_ff;
      s2_meta_in    = meta_cur;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_meta_in  = best_meta_ff;
      best_id_in    = best_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_seg_in    = rsp_seg_ff;
      rsp_file_in   = rsp_file_ff;
      rsp_done_in   = rsp_done_ff;

      meta_raddr    = iss_ff[IW-1:0];
      meta_we       = 1'b0;
      meta_waddr    = idx_ff;
      meta_wdata    = meta_cur;
      id_we         = 1'b0;
      id_waddr      = AW'(idx_ff) * AW'(ENTRIES) + AW'(meta_cur.len);
      id_raddr      = AW'(s1_idx_ff) * AW'(ENTRIES) + AW'(meta_cur.head);

      case (state_ff)
         kwms_pkg::ST_IDLE: begin
            // The descriptor read for an append or set is issued with acceptance.
            meta_raddr = IW'(req_idx);
            if (req_accept) begin
               kind_in   = req_kind;
               idx_in    = IW'(req_idx);
               seg_in    = req_seg;
               ident_in  = req_ident;
               iss_in    = '0;
               scan_n_in = lists_in_use;
               found_in  = 1'b0;
               if (req_kind == kwms_pkg::KIND_CLEAR) begin
                  meta_vld_in = '0;
               end
            end
         end
         kwms_pkg::ST_LOAD: begin
            meta_we             = 1'b1;
            meta_vld_in[idx_ff] = 1'b1;
            if (kind_ff == kwms_pkg::KIND_APPEND) begin
               if (meta_cur.len < LW'(ENTRIES)) begin
                  id_we          = 1'b1;
                  meta_wdata.len = meta_cur.len + LW'(1);
               end
            end else begin
               meta_wdata.seg = seg_ff;
            end
         end
         kwms_pkg::ST_SCAN: begin
            // Stage 0: issue one descriptor read per cycle.
            if (iss_ff < scan_n_ff) begin
               s1_v_in    = 1'b1;
               s1_last_in = (iss_ff + CW'(1) == scan_n_ff);
               iss_in     = iss_ff + CW'(1);
            end
            // Stage 1: descriptor arrives, the head identifier read goes out.
            s2_v_in = s1_v_ff;
            // Stage 2: head identifier arrives; strict compare keeps the lowest index on ties.
            if (s2_v_ff && s2_cand_ff && (!found_ff || id_rdata < best_id_ff)) begin
               found_in     = 1'b1;
               best_idx_in  = s2_idx_ff;
               best_meta_in = s2_meta_ff;
               best_id_in   = id_rdata;
            end
         end
         kwms_pkg::ST_COMMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  meta_we              = 1'b1;
                  meta_waddr           = best_idx_ff;
                  meta_wdata           = best_meta_ff;
                  meta_wdata.head      = best_meta_ff.head + LW'(1);
                  meta_vld_in[best_idx_ff] = 1'b1;
                  rsp_seg_in           = best_meta_ff.seg;
                  rsp_file_in          = {1'b0, best_id_ff};
                  rsp_done_in          = (best_id_ff == '0);
               end else begin
                  rsp_seg_in  = kwms_pkg::NO_SEGMENT;
                  rsp_file_in = kwms_pkg::NO_FILE;
                  rsp_done_in = 1'b1;
               end
            end
         end
         default: begin
            meta_we = 1'b0;
         end
      endcase

      // Capture the valid bit alongside every descriptor read.
      meta_rvld_in = meta_vld_ff[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kwms_pkg::ST_IDLE;
         list_count_ff <= kwms_pkg::LIST_COUNT_RESET;
         meta_vld_ff   <= '0;
         meta_rvld_ff  <= 1'b0;
         iss_ff        <= '0;
         scan_n_ff     <= '0;
         s1_v_ff       <= 1'b0;
         s1_last_ff    <= 1'b0;
         s2_v_ff       <= 1'b0;
         s2_last_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         list_count_ff <= list_count_in;
         meta_vld_ff   <= meta_vld_in;
         meta_rvld_ff  <= meta_rvld_in;
         iss_ff        <= iss_in;
         scan_n_ff     <= scan_n_in;
         s1_v_ff       <= s1_v_in;
         s1_last_ff    <= s1_last_in;
         s2_v_ff       <= s2_v_in;
         s2_last_ff    <= s2_last_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      seg_ff       <= seg_in;
      ident_ff     <= ident_in;
      s1_idx_ff    <= s1_idx_in;
      s2_cand_ff   <= s2_cand_in;
      s2_idx_ff    <= s2_idx_in;
      s2_meta_ff   <= s2_meta_in;
      best_idx_ff  <= best_idx_in;
      best_meta_ff <= best_meta_in;
      best_id_ff   <= best_id_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_file_ff  <= rsp_file_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_file_ff, rsp_seg_ff};
   assign rsp_tuser  = rsp_done_ff;

endmodule

`default_nettype wire

// ===== rtl/kwms_checker.sv =====
// Port-level checker of the k-way merge head selector and its bind to the top level.
`default_nettype none

module kwms_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [kwms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]                      rsp_tuser
);

   logic [kwms_pkg::SEG_W-1:0]  chk_seg;
   logic [kwms_pkg::FILE_W-1:0] chk_file;

   assign chk_seg  = rsp_tdata[kwms_pkg::RSP_SEG_LSB +: kwms_pkg::SEG_W];
   assign chk_file = rsp_tdata[kwms_pkg::RSP_FILE_LSB +: kwms_pkg::FILE_W];

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // No response is pending in the cycle after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A result that is not done carries a used segment and a positive identifier.
   a_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         !chk_seg[kwms_pkg::SEG_W-1] && !chk_file[kwms_pkg::FILE_W-1] && (chk_file != '0))
      else $error("result not marked done carries an invalid head");

   // The empty result is reported as done with no segment.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (chk_file == kwms_pkg::NO_FILE) |->
         rsp_tuser[0] && (chk_seg == kwms_pkg::NO_SEGMENT))
      else $error("empty result not reported consistently");

endmodule

bind kway_merge_head_selector_unit kwms_checker u_kwms_checker (.*);

`default_nettype wire
